FILE: hdl/ilha_pkg.sv
// ----------------------------------------------------------------------------
// ilha_pkg
// shared widths and defaults for the implicit list heap allocator
// ----------------------------------------------------------------------------
package ilha_pkg;

    // default heap depth in words
    localparam int HEAP_WORDS = 1024;

    // field widths of the command and result words
    localparam int LEN_W  = 11;
    localparam int ADDR_W = 10;

    // header word: even size above bit 0, bit 0 is the allocated mark
    localparam int HDR_W = 17;

    // position plus size, wide enough to never wrap
    localparam int SUM_W = HDR_W + 1;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

FILE: hdl/ilha_cmd_if.sv
// ----------------------------------------------------------------------------
// ilha_cmd_if
// command channel: allocate or free request words with valid/ready
// ----------------------------------------------------------------------------
interface ilha_cmd_if;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [ilha_pkg::LEN_W-1:0]  request_len;
    logic [ilha_pkg::ADDR_W-1:0] block_addr;

    modport source (
        output valid,
        output command,
        output request_len,
        output block_addr,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  request_len,
        input  block_addr,
        output ready
    );

endinterface

FILE: hdl/ilha_res_if.sv
// ----------------------------------------------------------------------------
// ilha_res_if
// result channel: block address and success flag with valid/ready
// ----------------------------------------------------------------------------
interface ilha_res_if;

    logic                       valid;
    logic                       ready;
    logic [ilha_pkg::ADDR_W-1:0] result_addr;
    logic                       success;

    modport source (
        output valid,
        output result_addr,
        output success,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_addr,
        input  success,
        output ready
    );

endinterface

FILE: hdl/implicit_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// first-fit heap allocator over an implicit list of block headers
// ----------------------------------------------------------------------------
// The heap headers live in one synchronous memory of HEAP_WORDS words with a
// registered read. After reset the block runs a clearing pass over every word
// (word 0 gets the whole heap as one free block, all others zero) and takes
// no command word until it is over. An allocate walks the headers from word 0,
// one header per cycle, limited by the single memory read port: it accepts
// the command, reads each header it visits, writes a remainder header when a
// free remainder is left, and hands the result to the output register. A free
// reads the block header, reads the following header if it lies inside the
// heap, writes back and hands over the result; an address at or past the heap
// end goes straight to the result. One command is worked at a time; a new
// command word is taken while the previous result word still waits in the
// output register.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator #(
    parameter int HEAP_WORDS = ilha_pkg::HEAP_WORDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ilha_cmd_if.sink     i_cmd,
    ilha_res_if.source   o_res
);

    localparam int LEN_W  = ilha_pkg::LEN_W;
    localparam int ADDR_W = ilha_pkg::ADDR_W;
    localparam int HDR_W  = ilha_pkg::HDR_W;
    localparam int SUM_W  = ilha_pkg::SUM_W;
    localparam int AW     = $clog2(HEAP_WORDS);

    // heap end as a wide compare value
    localparam logic [SUM_W-1:0] HEAP_END = SUM_W'(HEAP_WORDS);
    // initial header: whole heap, free, size forced even
    localparam logic [HDR_W-1:0] INIT_HDR = HDR_W'((HEAP_WORDS / 2) * 2);
    localparam logic [AW-1:0]    LAST_WORD = AW'(HEAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,   // reset sweep through the header memory
        S_IDLE,    // waiting for a command word
        S_AWALK,   // allocate: one header checked per cycle
        S_AREM,    // allocate: write the free remainder header
        S_FHEAD,   // free: header of the freed block is in
        S_FNEXT,   // free: header of the following block is in
        S_DONE     // result waits for the output register
    } t_state;

    // header memory
    logic [HDR_W-1:0] mem [HEAP_WORDS];

    // control state
    t_state           r_state,     n_state;
    logic [AW-1:0]    r_clr,       n_clr;
    logic             r_out_valid, n_out_valid;

    // payload registers
    logic [AW-1:0]     r_pos,      n_pos;
    logic [LEN_W-1:0]  r_len,      n_len;
    logic [HDR_W-1:0]  r_h,        n_h;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_res_ok,   n_res_ok;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic              r_out_ok,   n_out_ok;
    logic [HDR_W-1:0]  r_rd;

    // memory port controls
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [HDR_W-1:0] wr_data;

    // walk and free arithmetic
    logic [HDR_W-1:0] size;
    logic             fit;
    logic [LEN_W:0]   taken;
    logic [HDR_W-1:0] taken_h;
    logic [SUM_W-1:0] next_sum;
    logic [SUM_W-1:0] rem_sum;
    logic [SUM_W-1:0] addr_ext;
    logic             cmd_acc;
    logic             out_free;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.result_addr = r_out_addr;
    assign o_res.success     = r_out_ok;

    // size of the header just read, bit 0 dropped
    assign size     = {r_rd[HDR_W-1:1], 1'b0};
    assign fit      = !r_rd[0] && (size > HDR_W'(r_len));
    // request rounded up to even
    assign taken    = ((LEN_W + 1)'(r_len) + (LEN_W + 1)'(1)) & ~(LEN_W + 1)'(1);
    assign taken_h  = HDR_W'(taken);
    // start of the block after the one read
    assign next_sum = SUM_W'(r_pos) + SUM_W'(size);
    // start of the remainder after an allocation
    assign rem_sum  = SUM_W'(r_pos) + SUM_W'(taken);
    assign addr_ext = SUM_W'(i_cmd.block_addr);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_addr  = r_out_addr;
        n_out_ok    = r_out_ok;
        n_pos       = r_pos;
        n_len       = r_len;
        n_h         = r_h;
        n_res_addr  = r_res_addr;
        n_res_ok    = r_res_ok;
        rd_en       = 1'b0;
        rd_addr     = r_pos;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_h;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == '0) ? INIT_HDR : '0;
                if (r_clr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            S_IDLE: begin
                if (cmd_acc) begin
                    n_len = i_cmd.request_len;
                    if (i_cmd.command == ilha_pkg::CMD_ALLOC) begin
                        // walk starts at the heap base
                        n_pos   = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_AWALK;
                    end else begin
                        n_res_addr = i_cmd.block_addr;
                        if (addr_ext >= HEAP_END) begin
                            // out of range: nothing changes
                            n_res_ok = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = AW'(i_cmd.block_addr);
                            rd_en   = 1'b1;
                            rd_addr = AW'(i_cmd.block_addr);
                            n_state = S_FHEAD;
                        end
                    end
                end
            end

            S_AWALK: begin
                priority if (fit) begin
                    wr_en      = 1'b1;
                    wr_addr    = r_pos;
                    wr_data    = taken_h | HDR_W'(1);
                    n_res_addr = ADDR_W'(r_pos);
                    n_res_ok   = 1'b1;
                    if (taken_h < size && rem_sum < HEAP_END) begin
                        n_h     = size - taken_h;
                        n_pos   = AW'(rem_sum);
                        n_state = S_AREM;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (size == '0 || next_sum >= HEAP_END) begin
                    // zero-size header or heap end: no fitting block
                    n_res_addr = '0;
                    n_res_ok   = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    n_pos   = AW'(next_sum);
                    rd_en   = 1'b1;
                    rd_addr = AW'(next_sum);
                end
            end

            S_AREM: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_h;
                n_state = S_DONE;
            end

            S_FHEAD: begin
                n_h = size;
                if (next_sum < HEAP_END) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(next_sum);
                    n_state = S_FNEXT;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = r_pos;
                    wr_data  = size;
                    n_res_ok = 1'b1;
                    n_state  = S_DONE;
                end
            end

            S_FNEXT: begin
                // merge a free follower, sum wraps at header width
                wr_en    = 1'b1;
                wr_addr  = r_pos;
                wr_data  = r_rd[0] ? r_h : (r_h + r_rd);
                n_res_ok = 1'b1;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_ok    = r_res_ok;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_len      <= n_len;
        r_h        <= n_h;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
    end

    // header memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

endmodule
